>>> rtl/rgb_box_filter_top_defines.svh
// Assertion macros shared by the rgb_box_filter RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef RGB_BOX_FILTER_TOP_DEFINES_SVH
`define RGB_BOX_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define RBF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbf assertion failed");

// next-cycle implication
`define RBF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbf assertion failed");

`endif

>>> rtl/rbf_pkg.sv
// Shared types, constants and the reciprocal table of the box filter.
// No dependencies.
`default_nettype none

package rbf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HALF  = 3;
  localparam int MAX_HEIGHT    = 4096;

  localparam int DIM_W       = 13;  // frame dimensions and position counters
  localparam int POS_W       = 12;  // row / column of a stored pixel
  localparam int HALF_W      = 3;   // window radius
  localparam int RING_FW     = 4;   // ring row field in a command
  localparam int PIX_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int QDEPTH      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_HALF   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [HALF_W-1:0] half;
  } cfg_t;

  typedef struct packed {
    logic               wr;
    logic [RING_FW-1:0] wr_ring;
    logic [POS_W-1:0]   wr_col;
    logic [PIX_W-1:0]   px;
    logic               emit;
    logic [POS_W-1:0]   o_row;
    logic [POS_W-1:0]   o_col;
    logic [RING_FW-1:0] o_ring;
    logic               last;
  } cmd_t;

  // ceil(2^24 / (2h+1)^2); exact floor for every window sum of 8-bit pixels
  function automatic logic [RECIP_W-1:0] recip_of(input logic [HALF_W-1:0] half);
    logic [RECIP_W-1:0] m;
    case (half)
      3'd0:    m = 25'd16777216;
      3'd1:    m = 25'd1864136;
      3'd2:    m = 25'd671089;
      3'd3:    m = 25'd342393;
      3'd4:    m = 25'd207127;
      3'd5:    m = 25'd138655;
      3'd6:    m = 25'd99274;
      default: m = 25'd74566;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rgb_box_filter_top.sv
// Top level of the streaming RGB box filter: config registers, front end,
// command queue and window engine. Depends on rbf_pkg and all rbf_ modules.
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_ready  | mode, blue, green, red
//   out_       | out | out_valid/out_ready| blue, green, red, last_of_frame
//   cfg_       | in  | cfg_we             | cfg_idx, cfg_wdata
//
// The front end takes one beat per cycle while the 4-entry queue has room.
// A stored pixel with no output is written as the engine pops it; an
// output beat also walks its window on the single line-store read port, one
// tap a cycle, waits, multiplies and outputs. Reset is synchronous, active
// low; the line store needs no clearing. Output stalls back up the queue.
`default_nettype none

module rgb_box_filter_top #(
  parameter int MAX_WIDTH = rbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = rbf_pkg::DEF_MAX_HALF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_mode,
  input  wire logic [7:0]                       in_blue,
  input  wire logic [7:0]                       in_green,
  input  wire logic [7:0]                       in_red,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            out_blue,
  output logic [7:0]                            out_green,
  output logic [7:0]                            out_red,
  output logic                                  out_last_of_frame,
  input  wire logic                             cfg_we,
  input  wire logic [rbf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [rbf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import rbf_pkg::*;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  half_r;
  logic        restart;
  cfg_t        cfg;
  logic        q_push, q_pop, q_full, q_empty;
  cmd_t        q_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
      half_r   <= 2'd1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_WIDTH:  width_r  <= cfg_wdata[10:0];
        REG_HEIGHT: height_r <= cfg_wdata[12:0];
        REG_HALF:   half_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = cfg_we && (cfg_idx <= CFG_IDX_W'(REG_HALF));
    // clamp to the supported ranges
    cfg.w = DIM_W'(width_r);
    if (width_r == '0) cfg.w = DIM_W'(1);
    else if (DIM_W'(width_r) > DIM_W'(MAX_WIDTH)) cfg.w = DIM_W'(MAX_WIDTH);
    cfg.h = height_r;
    if (height_r == '0) cfg.h = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_HEIGHT)) cfg.h = DIM_W'(MAX_HEIGHT);
    cfg.half = HALF_W'(half_r);
    if (HALF_W'(half_r) > HALF_W'(MAX_HALF)) cfg.half = HALF_W'(MAX_HALF);
  end

  rbf_front #(
    .MAX_HALF (MAX_HALF)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .restart  (restart),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_blue  (in_blue),
    .in_green (in_green),
    .in_red   (in_red),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  rbf_cmd_fifo #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .cmd_in (q_cmd),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  rbf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .out_last  (out_last_of_frame)
  );

endmodule

`default_nettype wire

>>> rtl/rbf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rbf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rbf_front.sv
// Front end: accepts beats, tracks input and output raster positions and
// decides per beat whether a pixel is stored and whether an output is due.
// Depends on rbf_pkg.
`default_nettype none

module rbf_front #(
  parameter int MAX_HALF = rbf_pkg::DEF_MAX_HALF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rbf_pkg::cfg_t       cfg,
  input  wire logic                restart,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_mode,
  input  wire logic [7:0]          in_blue,
  input  wire logic [7:0]          in_green,
  input  wire logic [7:0]          in_red,
  input  wire logic                q_full,
  output logic                     q_push,
  output rbf_pkg::cmd_t            q_cmd
);

  import rbf_pkg::*;

  localparam int RING_ROWS = 2 * MAX_HALF + 2;
  localparam int RW        = $clog2(RING_ROWS);

  logic [DIM_W-1:0] in_row_r, in_row_nxt;
  logic [DIM_W-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0]    in_ring_r, in_ring_nxt;
  logic [DIM_W-1:0] out_row_r, out_row_nxt;
  logic [DIM_W-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0]    out_ring_r, out_ring_nxt;

  logic             done, is_px, emit, rdy, last, acc;
  logic [DIM_W-1:0] nr, nc, h_m1, w_m1, col_inc;

  always_comb begin
    h_m1  = cfg.h - DIM_W'(1);
    w_m1  = cfg.w - DIM_W'(1);
    done  = in_row_r >= cfg.h;
    is_px = !in_mode && !done;
    // last input pixel the next output needs, clamped to the frame
    nr = out_row_r + DIM_W'(cfg.half);
    if (nr > h_m1) nr = h_m1;
    nc = out_col_r + DIM_W'(cfg.half);
    if (nc > w_m1) nc = w_m1;
    rdy  = (nr < in_row_r) || ((nr == in_row_r) && (nc <= in_col_r));
    emit = is_px ? rdy : done;
    last = (out_row_r == h_m1) && (out_col_r == w_m1);
    in_ready = !q_full;
    acc      = in_valid && in_ready;
    q_push   = acc && (is_px || emit);

    q_cmd.wr      = is_px;
    q_cmd.wr_ring = RING_FW'(in_ring_r);
    q_cmd.wr_col  = in_col_r[POS_W-1:0];
    q_cmd.px      = {in_red, in_green, in_blue};
    q_cmd.emit    = emit;
    q_cmd.o_row   = out_row_r[POS_W-1:0];
    q_cmd.o_col   = out_col_r[POS_W-1:0];
    q_cmd.o_ring  = RING_FW'(out_ring_r);
    q_cmd.last    = last;

    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_ring_nxt  = in_ring_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_ring_nxt = out_ring_r;
    col_inc      = in_col_r + DIM_W'(1);

    if (restart) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_ring_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_ring_nxt = '0;
    end else if (acc) begin
      if (is_px) begin
        if (col_inc >= cfg.w) begin
          in_col_nxt  = '0;
          in_row_nxt  = in_row_r + DIM_W'(1);
          in_ring_nxt = (in_ring_r == RW'(RING_ROWS - 1)) ? '0 : in_ring_r + RW'(1);
        end else begin
          in_col_nxt = col_inc;
        end
      end
      if (emit) begin
        if (last) begin
          in_row_nxt   = '0;
          in_col_nxt   = '0;
          in_ring_nxt  = '0;
          out_row_nxt  = '0;
          out_col_nxt  = '0;
          out_ring_nxt = '0;
        end else if (out_col_r == w_m1) begin
          out_col_nxt  = '0;
          out_row_nxt  = out_row_r + DIM_W'(1);
          out_ring_nxt = (out_ring_r == RW'(RING_ROWS - 1)) ? '0 : out_ring_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + DIM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_ring_r  <= in_ring_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_ring_r <= out_ring_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rbf_cmd_fifo.sv
// Short command queue between front end and window engine.
// Depends on rbf_pkg and rgb_box_filter_top_defines.svh.
`default_nettype none
`include "rgb_box_filter_top_defines.svh"

module rbf_cmd_fifo #(
  parameter int DEPTH = rbf_pkg::QDEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rbf_pkg::cmd_t cmd_in,
  input  wire logic          pop,
  output rbf_pkg::cmd_t      head,
  output logic               full,
  output logic               empty
);

  import rbf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t            slot_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  assign full  = cnt_r == CNTW'(DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  `RBF_ASSERT_IMP(a_no_push_full, full, !push)
  `RBF_ASSERT_IMP(a_no_pop_empty, empty, !pop)

endmodule

`default_nettype wire

>>> rtl/rbf_back.sv
// Window engine: writes pixels to the line store, walks the window taps,
// sums per channel and divides by the area through a reciprocal.
// Depends on rbf_pkg, rbf_ram and rgb_box_filter_top_defines.svh.
`default_nettype none
`include "rgb_box_filter_top_defines.svh"

module rbf_back #(
  parameter int MAX_WIDTH = rbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = rbf_pkg::DEF_MAX_HALF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rbf_pkg::cfg_t cfg,
  input  wire logic          q_empty,
  input  wire rbf_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_green,
  output logic [7:0]         out_red,
  output logic               out_last
);

  import rbf_pkg::*;

  localparam int RING_ROWS = 2 * MAX_HALF + 2;
  localparam int RW        = $clog2(RING_ROWS);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int AW        = RW + CW;
  localparam int MEM_DEPTH = RING_ROWS * (2 ** CW);
  localparam int SPAN      = 2 * MAX_HALF + 1;
  localparam int SUM_W     = $clog2(255 * SPAN * SPAN + 1);
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int TW        = DIM_W + 1;
  localparam int KW        = HALF_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_WAIT, S_MUL, S_OUT} state_t;

  state_t              state_r;
  logic signed [TW-1:0] tr_r, tc_r, c0_r;
  logic [RW-1:0]       tring_r;
  logic [KW-1:0]       di_r, dj_r;
  logic                last_r, tap_ok_d_r, out_valid_r, out_last_r;
  logic [SUM_W-1:0]    acc_b_r, acc_g_r, acc_r_r;
  logic [PROD_W-1:0]   prod_b_r, prod_g_r, prod_r_r;
  logic [7:0]          out_b_r, out_g_r, out_rd_r;

  logic                tap_ok, out_free, ram_re, out_set;
  logic [KW-1:0]       span_m1;
  logic [RW:0]         ring_start;
  logic [AW-1:0]       waddr, raddr;
  logic [PIX_W-1:0]    rdata;
  logic [RECIP_W-1:0]  recip;

  always_comb begin
    q_pop    = (state_r == S_IDLE) && !q_empty;
    span_m1  = {cfg.half, 1'b0};
    tap_ok   = !tr_r[TW-1] && (tr_r[TW-2:0] < cfg.h) &&
               !tc_r[TW-1] && (tc_r[TW-2:0] < cfg.w);
    ram_re   = (state_r == S_SUM) && tap_ok;
    waddr    = {q_head.wr_ring[RW-1:0], q_head.wr_col[CW-1:0]};
    raddr    = {tring_r, tc_r[CW-1:0]};
    out_free = !out_valid_r || out_ready;
    out_set  = (state_r == S_OUT) && out_free;
    recip    = recip_of(cfg.half);
    // first window row on the ring, wrapped
    ring_start = {1'b0, q_head.o_ring[RW-1:0]} + (RW + 1)'(RING_ROWS) - (RW + 1)'(cfg.half);
    if (ring_start >= (RW + 1)'(RING_ROWS)) begin
      ring_start = ring_start - (RW + 1)'(RING_ROWS);
    end
  end

  rbf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (q_pop && q_head.wr),
    .waddr (waddr),
    .wdata (q_head.px),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_ok_d_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tap_ok_d_r <= ram_re;
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop && q_head.emit) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          if (dj_r == span_m1 && di_r == span_m1) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: state_r <= S_MUL;
        S_MUL:  state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      acc_b_r <= '0;
      acc_g_r <= '0;
      acc_r_r <= '0;
      if (q_pop) begin
        tr_r    <= $signed({2'b00, q_head.o_row}) - $signed(TW'(cfg.half));
        tc_r    <= $signed({2'b00, q_head.o_col}) - $signed(TW'(cfg.half));
        c0_r    <= $signed({2'b00, q_head.o_col}) - $signed(TW'(cfg.half));
        tring_r <= ring_start[RW-1:0];
        last_r  <= q_head.last;
        di_r    <= '0;
        dj_r    <= '0;
      end
    end else if (tap_ok_d_r) begin
      acc_b_r <= acc_b_r + SUM_W'(rdata[7:0]);
      acc_g_r <= acc_g_r + SUM_W'(rdata[15:8]);
      acc_r_r <= acc_r_r + SUM_W'(rdata[23:16]);
    end
    if (state_r == S_SUM) begin
      if (dj_r == span_m1) begin
        dj_r    <= '0;
        tc_r    <= c0_r;
        di_r    <= di_r + KW'(1);
        tr_r    <= tr_r + TW'(1);
        tring_r <= (tring_r == RW'(RING_ROWS - 1)) ? '0 : tring_r + RW'(1);
      end else begin
        dj_r <= dj_r + KW'(1);
        tc_r <= tc_r + TW'(1);
      end
    end
    if (state_r == S_MUL) begin
      prod_b_r <= PROD_W'(acc_b_r) * PROD_W'(recip);
      prod_g_r <= PROD_W'(acc_g_r) * PROD_W'(recip);
      prod_r_r <= PROD_W'(acc_r_r) * PROD_W'(recip);
    end
    if (state_r == S_OUT && out_free) begin
      out_b_r    <= prod_b_r[RECIP_SHIFT+7:RECIP_SHIFT];
      out_g_r    <= prod_g_r[RECIP_SHIFT+7:RECIP_SHIFT];
      out_rd_r   <= prod_r_r[RECIP_SHIFT+7:RECIP_SHIFT];
      out_last_r <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = out_b_r;
  assign out_green = out_g_r;
  assign out_red   = out_rd_r;
  assign out_last  = out_last_r;

  `RBF_ASSERT_IMP(a_tap_from_sum, tap_ok_d_r, $past(state_r) == S_SUM)
  `RBF_ASSERT_NXT(a_emit_starts_sum, q_pop && q_head.emit, state_r == S_SUM)
  `RBF_ASSERT_NXT(a_out_loaded, state_r == S_OUT && out_free, out_valid_r)

endmodule

`default_nettype wire

>>> sim/tb_rgb_box_filter_top.sv
// Testbench for rgb_box_filter_top: random and directed pixel frames checked
// beat by beat against an in-bench window-mean predictor. Depends on rbf_pkg.
`timescale 1ns / 1ps

module tb_rgb_box_filter_top;
  import rbf_pkg::*;

  localparam int RING_ROWS = 2 * DEF_MAX_HALF + 2;
  localparam int SETTLE = 120;  // one full window walk plus queue drain, with margin
  localparam int RAND_PIXELS = 150;
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } mean_px_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_mode;
  logic [7:0] in_blue, in_green, in_red;
  logic out_valid, out_ready;
  logic [7:0] out_blue, out_green, out_red;
  logic out_last_of_frame;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rgb_box_filter_top uut (.*);

  // predictor state
  logic [23:0] ring_px [RING_ROWS*DEF_MAX_WIDTH];
  int unsigned row_pos, col_pos, emitted;
  int unsigned reg_w, reg_h, reg_half;
  mean_px_t mean_q[$];

  int err_count = 0;
  int snd_idle_pct = 0, rcv_idle_pct = 0;
  int hold_cycles = 0;
  int pixels_sent = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned eff_w();
    return (reg_w == 0) ? 1 : (reg_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : reg_w;
  endfunction
  function automatic int unsigned eff_h();
    return (reg_h == 0) ? 1 : (reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h;
  endfunction

  function automatic mean_px_t window_mean();
    int unsigned w, h, hh, area, sb, sg, sr;
    int er, ec, rr, cc;
    logic [23:0] p;
    mean_px_t m;
    w = eff_w(); h = eff_h(); hh = reg_half;
    area = (2 * hh + 1) * (2 * hh + 1);
    er = emitted / w; ec = emitted % w;
    sb = 0; sg = 0; sr = 0;
    for (int dr = -int'(hh); dr <= int'(hh); dr++)
      for (int dc = -int'(hh); dc <= int'(hh); dc++) begin
        rr = er + dr; cc = ec + dc;
        if (rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
          p = ring_px[(rr % RING_ROWS) * DEF_MAX_WIDTH + cc];
          sb += p[7:0]; sg += p[15:8]; sr += p[23:16];
        end
      end
    m.blue = 8'(sb / area); m.green = 8'(sg / area); m.red = 8'(sr / area);
    emitted++;
    m.last = (emitted >= w * h);
    if (m.last) begin
      row_pos = 0; col_pos = 0; emitted = 0;
    end
    return m;
  endfunction

  task automatic predict_beat(logic mode, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned w, h, hh, n, nr, nc;
    bit done;
    w = eff_w(); h = eff_h(); hh = reg_half;
    done = row_pos >= h;
    if (mode == MODE_PIXEL && !done) begin
      if (col_pos >= w) col_pos = 0;
      n = row_pos * w + col_pos;
      ring_px[(row_pos % RING_ROWS) * DEF_MAX_WIDTH + col_pos] = {r, g, b};
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (emitted < w * h) begin
        nr = emitted / w + hh; nc = emitted % w + hh;
        if (nr > h - 1) nr = h - 1;
        if (nc > w - 1) nc = w - 1;
        if (nr * w + nc <= n) mean_q.push_back(window_mean());
      end
    end else if (done && emitted < w * h) begin
      mean_q.push_back(window_mean());
    end
  endtask

  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $realtime, what);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    mean_px_t e;
    if (rst_n && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        report_mismatch("unexpected output beat");
      end else begin
        e = mean_q.pop_front();
        if (out_blue !== e.blue)
          report_mismatch($sformatf("blue %0d, want %0d", out_blue, e.blue));
        if (out_green !== e.green)
          report_mismatch($sformatf("green %0d, want %0d", out_green, e.green));
        if (out_red !== e.red)
          report_mismatch($sformatf("red %0d, want %0d", out_red, e.red));
        if (out_last_of_frame !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last_of_frame, e.last));
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // caller is right after a rising edge
  task automatic send_beat(logic mode, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    do @(posedge clk); while (!in_ready);
    predict_beat(mode, b, g, r);
    if (mode == MODE_PIXEL) pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  reg_w = data[10:0];
      REG_HEIGHT: reg_h = data;
      REG_HALF:   reg_half = data[1:0];
      default:    return;
    endcase
    row_pos = 0; col_pos = 0; emitted = 0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned hh);
    wait_idle();
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_HALF, CFG_DATA_W'(hh));
  endtask

  // full frame of random pixels, a few ignored early flushes, then drain
  task automatic run_frame(int noise_pct);
    int unsigned total;
    total = eff_w() * eff_h();
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_beat(MODE_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      send_beat(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    // pixels after frame input completes act as flushes
    while (row_pos >= eff_h())
      send_beat($urandom_range(3) != 0 ? MODE_FLUSH : MODE_PIXEL,
                8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    set_frame(3, 3, 1);
    send_beat(MODE_FLUSH, 8'hff, 8'hff, 8'hff);  // ignored, frame not complete
    for (int i = 0; i < 9; i++)
      send_beat(MODE_PIXEL, (i % 2) ? 8'hff : 8'h00, 8'hff, (i < 4) ? 8'h00 : 8'hff);
    send_beat(MODE_PIXEL, 8'h12, 8'h34, 8'h56);  // data ignored, acts as flush
    while (row_pos >= eff_h()) send_beat(MODE_FLUSH, 8'h00, 8'h00, 8'h00);
    set_frame(2, 2, 0);
    for (int i = 0; i < 4; i++) send_beat(MODE_PIXEL, 8'hff, 8'h00, 8'h80);
    set_frame(2, 2, 3);  // window larger than the image
    for (int i = 0; i < 4; i++) send_beat(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
    while (row_pos >= eff_h()) send_beat(MODE_FLUSH, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_register_extremes();
    set_frame(0, 1, 3);              // width 0 clamps to 1
    run_frame(0);
    set_frame(11'h7ff, 0, 2);        // width clamps to max, height 0 to 1
    run_frame(0);
    set_frame(1, 13'h1fff, 0);       // height clamps to 4096; partial frame only
    repeat (40) send_beat(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_idle();
    write_reg(REG_UNUSED, 13'h1555); // no effect, not even a restart
    set_frame(5, 4, 1);
    run_frame(10);
  endtask

  task automatic test_mid_frame_restart();
    set_frame(6, 5, 2);
    repeat (17) send_beat(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_idle();
    write_reg(REG_HALF, 1);
    run_frame(0);
  endtask

  task automatic test_backpressure();
    set_frame(8, 6, 1);
    hold_cycles <= 400;
    run_frame(0);
  endtask

  task automatic test_random();
    int phase, base;
    base = pixels_sent;
    while (pixels_sent - base < RAND_PIXELS) begin
      phase = (pixels_sent - base) * 3 / RAND_PIXELS;
      snd_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 72 : 0;
      rcv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 33 : 0;
      set_frame($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 3));
      run_frame(5);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_mode = 1'b0;
    in_blue = 8'h00; in_green = 8'h00; in_red = 8'h00;
    cfg_we = 1'b0; cfg_idx = REG_WIDTH; cfg_wdata = '0;
    foreach (ring_px[i]) ring_px[i] = '0;
    row_pos = 0; col_pos = 0; emitted = 0;
    reg_w = 640; reg_h = 480; reg_half = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle_pct = 33; rcv_idle_pct = 72;
    test_directed();
    test_register_extremes();
    test_mid_frame_restart();
    test_backpressure();
    test_random();
    wait_idle();
    if (mean_q.size() != 0) report_mismatch("expected outputs never arrived");
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rbf_pkg.sv
rtl/rbf_ram.sv
rtl/rbf_front.sv
rtl/rbf_cmd_fifo.sv
rtl/rbf_back.sv
rtl/rgb_box_filter_top.sv
sim/tb_rgb_box_filter_top.sv
